// ===== hw/rtl/b58dec_pkg.sv =====
// Shared constants, types and the alphabet lookup for the base58 decoder.
package b58dec_pkg;

   localparam int MAX_BYTES = 64;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int LEN_W     = $clog2(MAX_BYTES + 1);
   localparam int RADIX     = 58;
   localparam int PROD_W    = 14;
   localparam int CARRY_W   = 6;

   typedef logic [1:0] status_type;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_BAD_CHAR = 2'd1;
   localparam status_type ST_TOO_LONG = 2'd2;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } digit_type;

   // Map an ASCII code onto its Bitcoin-alphabet digit.
   function automatic digit_type digit_of(input logic [7:0] code);
      digit_type d;
      d.valid = 1'b1;
      d.value = 6'd0;
      if (code >= 8'h31 && code <= 8'h39) begin
         d.value = 6'(code - 8'h31);
      end else if (code >= 8'h41 && code <= 8'h48) begin
         d.value = 6'(code - 8'h41 + 8'd9);
      end else if (code >= 8'h4A && code <= 8'h4E) begin
         d.value = 6'(code - 8'h4A + 8'd17);
      end else if (code >= 8'h50 && code <= 8'h5A) begin
         d.value = 6'(code - 8'h50 + 8'd22);
      end else if (code >= 8'h61 && code <= 8'h6B) begin
         d.value = 6'(code - 8'h61 + 8'd33);
      end else if (code >= 8'h6D && code <= 8'h7A) begin
         d.value = 6'(code - 8'h6D + 8'd44);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

// ===== hw/rtl/b58dec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module b58dec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/base58_decoder_unit.sv =====
// Base58 (Bitcoin alphabet) string decoder, top level.
//
// Characters enter one word at a time on req_; req_tlast marks the last one.
// A leading '1', an invalid character, or any character after an error is
// handled in S_IDLE alone. Any other character runs a multiply-by-58 carry
// pass over the stored number in S_MUL, one byte per cycle through the
// number RAM's read and write ports. After the last character the block
// sends the leading zero bytes, then the number's bytes, most significant
// first (each read in S_EMIT_RD and sent from S_EMIT_WR, through the RAM's
// registered read), with rsp_tlast on the final word; output waits while
// rsp_tready is low. An invalid character or a result over MAX_BYTES bytes
// gives a single word with data 0 and the error in rsp_tuser.
// The number RAM needs no clearing after reset.
module base58_decoder_unit
   import b58dec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // final_char
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] data_byte
   output logic [1:0] rsp_tuser,   // [1:0] status
   output logic       rsp_tlast    // last_byte
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_MUL     = 3'd1;
   localparam logic [2:0] S_FIN     = 3'd2;
   localparam logic [2:0] S_EMIT_Z  = 3'd3;
   localparam logic [2:0] S_EMIT_RD = 3'd4;
   localparam logic [2:0] S_EMIT_WR = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   lead_ff, lead_in;
   logic               still_ff, still_in;
   status_type         err_ff, err_in;
   logic               fin_ff, fin_in;
   logic [LEN_W-1:0]   idx_ff, idx_in;
   logic [ADDR_W-1:0]  wr_idx_ff, wr_idx_in;
   logic               pend_ff, pend_in;
   logic [CARRY_W-1:0] carry_ff, carry_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [7:0]         ram_wdata;
   logic               ram_re;
   logic [7:0]         ram_rdata;

   digit_type          dig;
   logic               req_fire;
   logic               out_free;
   logic [LEN_W:0]     total;
   logic               full;
   logic               issue;
   logic [PROD_W-1:0]  prod;

   b58dec_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign dig        = digit_of(req_tdata);
   assign total      = {1'b0, lead_ff} + {1'b0, len_ff};
   assign full       = (total >= (LEN_W + 1)'(MAX_BYTES));
   assign issue      = (idx_ff < len_ff);
   assign prod       = {6'd0, ram_rdata} * PROD_W'(RADIX) + PROD_W'(carry_ff);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      lead_in       = lead_ff;
      still_in      = still_ff;
      err_in        = err_ff;
      fin_in        = fin_ff;
      idx_in        = idx_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = 1'b0;
      carry_in      = carry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      ram_we        = 1'b0;
      ram_waddr     = wr_idx_ff;
      ram_wdata     = prod[7:0];
      ram_re        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               fin_in   = req_tlast;
               state_in = req_tlast ? S_FIN : S_IDLE;
               if (err_ff != ST_OK) begin
                  // drop characters after an error
               end else if (!dig.valid) begin
                  err_in = ST_BAD_CHAR;
               end else if (still_ff && dig.value == 6'd0) begin
                  if (full) begin
                     err_in = ST_TOO_LONG;
                  end else begin
                     lead_in = lead_ff + LEN_W'(1);
                  end
               end else begin
                  still_in = 1'b0;
                  carry_in = dig.value;
                  idx_in   = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (issue) begin
               ram_re    = 1'b1;
               idx_in    = idx_ff + LEN_W'(1);
               wr_idx_in = idx_ff[ADDR_W-1:0];
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               ram_we   = 1'b1;
               carry_in = prod[PROD_W-1:8];
            end else if (!issue) begin
               if (carry_ff != '0) begin
                  if (full) begin
                     err_in = ST_TOO_LONG;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = len_ff[ADDR_W-1:0];
                     ram_wdata = {2'd0, carry_ff};
                     len_in    = len_ff + LEN_W'(1);
                  end
               end
               state_in = fin_ff ? S_FIN : S_IDLE;
            end
         end
         S_FIN: begin
            if (err_ff != ST_OK || total == '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_data_in   = 8'd0;
                  rsp_status_in = err_ff;
                  rsp_last_in   = 1'b1;
                  len_in        = '0;
                  lead_in       = '0;
                  still_in      = 1'b1;
                  err_in        = ST_OK;
                  state_in      = S_IDLE;
               end
            end else if (lead_ff != '0) begin
               state_in = S_EMIT_Z;
            end else begin
               idx_in   = len_ff - LEN_W'(1);
               state_in = S_EMIT_RD;
            end
         end
         S_EMIT_Z: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = 8'd0;
               rsp_status_in = ST_OK;
               rsp_last_in   = (total == (LEN_W + 1)'(1));
               lead_in       = lead_ff - LEN_W'(1);
               if (lead_ff == LEN_W'(1)) begin
                  if (len_ff == '0) begin
                     still_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = len_ff - LEN_W'(1);
                     state_in = S_EMIT_RD;
                  end
               end
            end
         end
         S_EMIT_RD: begin
            ram_re   = 1'b1;
            state_in = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = ram_rdata;
               rsp_status_in = ST_OK;
               rsp_last_in   = (idx_ff == '0);
               if (idx_ff == '0) begin
                  len_in   = '0;
                  lead_in  = '0;
                  still_in = 1'b1;
                  err_in   = ST_OK;
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - LEN_W'(1);
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         lead_ff      <= '0;
         still_ff     <= 1'b1;
         err_ff       <= ST_OK;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         lead_ff      <= lead_in;
         still_ff     <= still_in;
         err_ff       <= err_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff        <= fin_in;
      idx_ff        <= idx_in;
      wr_idx_ff     <= wr_idx_in;
      carry_ff      <= carry_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for base58_decoder_unit with a byte predictor and random strings.
`timescale 1ns / 1ps

module tb;
   import b58dec_pkg::*;

   localparam string B58_CHARS =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   base58_decoder_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   class b58_decode_check;
      typedef struct packed {
         logic [7:0] data;
         status_type status;
         logic       last;
      } out_word_type;

      out_word_type due_bytes[$];
      logic [7:0]   num_bytes[MAX_BYTES];
      int unsigned  num_len;
      int unsigned  lead_zeros;
      bit           in_lead;
      status_type   fault;
      int unsigned  mismatches;

      function new();
         mismatches = 0;
         clear_number();
      endfunction

      function void clear_number();
         num_len    = 0;
         lead_zeros = 0;
         in_lead    = 1'b1;
         fault      = ST_OK;
      endfunction

      function int digit_value(logic [7:0] c);
         for (int i = 0; i < 58; i++) begin
            if (B58_CHARS[i] == c) return i;
         end
         return -1;
      endfunction

      function void flag_fault(status_type code);
         if (fault == ST_OK) fault = code;
      endfunction

      function void absorb_char(logic [7:0] c);
         int          d;
         int unsigned carry;
         d = digit_value(c);
         if (d < 0) begin
            flag_fault(ST_BAD_CHAR);
            return;
         end
         if (in_lead && d == 0) begin
            if (lead_zeros + num_len >= MAX_BYTES) begin
               flag_fault(ST_TOO_LONG);
               return;
            end
            lead_zeros++;
            return;
         end
         in_lead = 1'b0;
         carry = d;
         for (int unsigned i = 0; i < num_len; i++) begin
            carry += num_bytes[i] * RADIX;
            num_bytes[i] = carry[7:0];
            carry >>= 8;
         end
         while (carry > 0) begin
            if (lead_zeros + num_len >= MAX_BYTES) begin
               flag_fault(ST_TOO_LONG);
               return;
            end
            num_bytes[num_len] = carry[7:0];
            num_len++;
            carry >>= 8;
         end
      endfunction

      function void push_word(logic [7:0] d, status_type s, logic l);
         out_word_type w;
         w.data   = d;
         w.status = s;
         w.last   = l;
         due_bytes = {due_bytes, w};
      endfunction

      function void take_char(logic [7:0] c, bit fin);
         int unsigned total;
         int unsigned n;
         if (fault == ST_OK) absorb_char(c);
         if (!fin) return;
         if (fault != ST_OK) begin
            push_word(8'h00, fault, 1'b1);
         end else begin
            total = lead_zeros + num_len;
            n = 0;
            if (total == 0) push_word(8'h00, ST_OK, 1'b1);
            for (int unsigned i = 0; i < lead_zeros && n < MAX_BYTES; i++) begin
               push_word(8'h00, ST_OK, n + 1 == total);
               n++;
            end
            for (int unsigned i = num_len; i > 0 && n < MAX_BYTES; i--) begin
               push_word(num_bytes[i - 1], ST_OK, n + 1 == total);
               n++;
            end
         end
         clear_number();
      endfunction

      function void match_byte(logic [7:0] d, logic [1:0] s, logic l);
         out_word_type w;
         if (due_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected word data %02h status %0d last %0b", d, s, l);
            return;
         end
         w = due_bytes.pop_front();
         if (d !== w.data || s !== w.status || l !== w.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: mismatch exp data %02h status %0d last %0b, got %02h %0d %0b",
                        w.data, w.status, w.last, d, s, l);
         end
      endfunction

      function int pending();
         return due_bytes.size();
      endfunction
   endclass

   b58_decode_check chk = new();
   bit              quiet = 1'b0;
   int              sent_chars = 0;
   logic [7:0]      text_q[$];
   logic [7:0]      odd_codes[13] = '{8'h00, 8'h30, 8'h3A, 8'h40, 8'h49, 8'h4F, 8'h5B,
                                      8'h60, 8'h6C, 8'h7B, 8'h7F, 8'h80, 8'hFF};

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

   task automatic queue_char(input logic [7:0] code);
      text_q = {text_q, code};
   endtask

   task automatic send_char(input logic [7:0] code, input bit fin);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = code;
      req_tlast  = fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chk.take_char(code, fin);
      sent_chars++;
   endtask

   task automatic send_text_q();
      for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   task automatic load_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(s[i]);
   endtask

   task automatic drain_wait();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
   endtask

   task automatic build_short();
      int kind;
      int len;
      int lead;
      int bad_at;
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 8);
      lead = $urandom_range(0, 2);
      if (kind == 8) begin
         repeat (len) queue_char(8'($urandom_range(0, 255)));
      end else begin
         repeat (lead) queue_char("1");
         repeat (len) queue_char(B58_CHARS[$urandom_range(0, 57)]);
         if (kind == 7) begin
            bad_at = $urandom_range(0, text_q.size() - 1);
            if ($urandom_range(0, 1) == 0)
               text_q[bad_at] = odd_codes[$urandom_range(0, 12)];
            else
               text_q[bad_at] = 8'($urandom_range(0, 255));
         end
      end
   endtask

   task automatic build_long_number();
      int lead;
      int body;
      lead = $urandom_range(20, 30);
      body = (64 - lead) * 1366 / 1000 - 2 + $urandom_range(0, 4);
      repeat (lead) queue_char("1");
      queue_char(B58_CHARS[$urandom_range(1, 57)]);
      repeat (body - 1) begin
         if ($urandom_range(0, 1) == 0) queue_char("z");
         else queue_char(B58_CHARS[$urandom_range(0, 57)]);
      end
   endtask

   initial begin
      int strings;
      int tail;
      int leftover;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      load_text("1");          send_text_q();
      load_text("z");          send_text_q();
      load_text("11");         send_text_q();
      send_char(8'h00, 1'b1);
      send_char(8'hFF, 1'b1);
      load_text("l2");         send_text_q();
      load_text("21");         send_text_q();
      load_text("0I");         send_text_q();
      load_text("9AHJNPZakm"); send_text_q();

      strings = 0;
      while (sent_chars < 60) begin
         quiet = ($urandom_range(0, 4) == 0);
         build_short();
         send_text_q();
         strings++;
         if (strings == 3 || $urandom_range(0, 9) == 0) drain_wait();
      end

      quiet = 1'b0;
      repeat (64) queue_char("1");
      tail = $urandom_range(0, 2);
      if (tail == 1) queue_char("1");
      if (tail == 2) queue_char("z");
      send_text_q();
      quiet = ($urandom_range(0, 2) == 0);
      build_long_number();
      send_text_q();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      leftover = chk.pending();
      if (chk.mismatches == 0 && leftover == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         gap = quiet ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         chk.match_byte(rsp_tdata, rsp_tuser, rsp_tlast);
      end
   end

endmodule
